/* rtl/core/ltsq_pkg.sv */
// ----------------------------------------------------------------------------
// Loop transport sequencer package
// Shared codes, state machine type, queue control type and helpers.
// ----------------------------------------------------------------------------
package ltsq_pkg;

  localparam int PLAN_DEPTH_DEF = 8;
  localparam int DATA_W         = 32;
  localparam int CD_W           = 17;

  localparam logic [2:0] ACT_PROCESS  = 3'd0;
  localparam logic [2:0] ACT_PLAN     = 3'd1;
  localparam logic [2:0] ACT_SET_MODE = 3'd2;
  localparam logic [2:0] ACT_SET_POS  = 3'd3;
  localparam logic [2:0] ACT_SET_LEN  = 3'd4;
  localparam logic [2:0] ACT_CLEAR    = 3'd5;
  localparam logic [2:0] ACT_SYNC     = 3'd6;

  localparam logic [2:0] MODE_STOPPED = 3'd0;
  localparam logic [2:0] MODE_PLAY    = 3'd1;
  localparam logic [2:0] MODE_RECORD  = 3'd2;
  localparam logic [2:0] MODE_REPLACE = 3'd3;
  localparam logic [2:0] MODE_DRY_WET = 3'd4;
  localparam logic [2:0] MODE_REC_DRY = 3'd5;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BEYOND  = 2'd1;
  localparam logic [1:0] ERR_INVALID = 2'd2;
  localparam logic [1:0] ERR_FULL    = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_P_CHK, ST_P_ADV, ST_P_MAX, ST_P_MIN, ST_P_ETA,
    ST_P_END, ST_P_SETTLE, ST_T_START, ST_T_DEC, ST_T_POP, ST_CM, ST_S_ZERO,
    ST_E_OWN, ST_E_SRC, ST_PL_SRCH, ST_PL_INS, ST_PL_ETA, ST_L_CMP, ST_L_POS,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {Q_NONE, Q_WRITE, Q_SHIFT} q_op_t;

  typedef struct packed {
    q_op_t            op;
    logic [CD_W-1:0]  cd;
    logic [2:0]       mode;
  } q_ctrl_t;

  function automatic logic is_playing(input logic [2:0] m);
    is_playing = (m == MODE_PLAY) || (m == MODE_REPLACE) ||
                 (m == MODE_DRY_WET) || (m == MODE_REC_DRY);
  endfunction

endpackage

/* rtl/core/ltsq_alu.sv */
// ----------------------------------------------------------------------------
// Loop transport sequencer shared adder
// One 32-bit add or subtract with carry or borrow out, shared by the sequencer steps.
// ----------------------------------------------------------------------------
module ltsq_alu
  import ltsq_pkg::*;
(
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  input  logic              sub,
  output logic [DATA_W:0]   y
);

  // For a subtract the top bit is the borrow.
  assign y = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});

endmodule

/* rtl/core/ltsq_plan_queue.sv */
// ----------------------------------------------------------------------------
// Loop transport sequencer plan queue
// Sorted storage of planned modes and countdowns, with write and head pop.
// ----------------------------------------------------------------------------
module ltsq_plan_queue
  import ltsq_pkg::*;
#(
  parameter int PLAN_DEPTH = PLAN_DEPTH_DEF,
  localparam int IW = (PLAN_DEPTH > 1) ? $clog2(PLAN_DEPTH) : 1
) (
  input  logic            clk,
  input  q_ctrl_t         ctrl,
  input  logic [IW-1:0]   idx,
  output logic [CD_W-1:0] rd_cd,
  output logic [2:0]      rd_mode,
  output logic [CD_W-1:0] head_cd,
  output logic [2:0]      head_mode
);

  logic [CD_W-1:0] cd_r   [PLAN_DEPTH];
  logic [2:0]      mode_r [PLAN_DEPTH];

  // Entries are only read below the fill, so no reset is needed.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      Q_WRITE: begin
        cd_r[idx]   <= ctrl.cd;
        mode_r[idx] <= ctrl.mode;
      end
      Q_SHIFT: begin
        for (int i = 0; i < PLAN_DEPTH - 1; i++) begin
          cd_r[i]   <= cd_r[i+1];
          mode_r[i] <= mode_r[i+1];
        end
      end
      default: ;
    endcase
  end

  assign rd_cd     = cd_r[idx];
  assign rd_mode   = mode_r[idx];
  assign head_cd   = cd_r[0];
  assign head_mode = mode_r[0];

endmodule

/* rtl/core/loop_transport_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Loop transport sequencer core
// Transport of one audio loop with a queue of planned mode changes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The item is then
// worked through by a small sequencer that drives one shared 32-bit adder,
// one step per cycle, so busy stays high for the whole item. When the item is
// finished, out_valid is high for exactly one cycle with the full transport
// state on the out_ ports; the receiver cannot hold results off, and busy
// falls in the next cycle.
// A process item that fires a trigger walks the queue once to count every
// entry down and then pops and applies due entries through the adder. A plan
// item walks the queue once to find its slot. The configuration bit is
// written by cfg_we and cfg_wdata; the user must write it only while idle,
// as the block itself does not enforce this. Reset (rst_n low at a clock
// edge) stops the loop, zeroes the position, length, predictions and flags,
// and empties the queue.
// ----------------------------------------------------------------------------
module loop_transport_sequencer_core
  import ltsq_pkg::*;
#(
  parameter int PLAN_DEPTH = PLAN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_sample_count,
  input  logic [2:0]  in_target_mode,
  input  logic [15:0] in_delay_cycles,
  input  logic        in_wait_for_sync,
  input  logic [31:0] in_new_value,
  input  logic        in_sync_triggering,
  input  logic        in_sync_playing,
  input  logic        in_sync_eta_valid,
  input  logic [31:0] in_sync_eta,
  output logic        out_valid,
  output logic [2:0]  out_mode_now,
  output logic [31:0] out_position_now,
  output logic [31:0] out_length_now,
  output logic        out_triggering,
  output logic        out_eta_valid,
  output logic [31:0] out_eta_samples,
  output logic        out_next_plan_valid,
  output logic [2:0]  out_next_plan_mode,
  output logic [15:0] out_next_plan_delay,
  output logic [3:0]  out_plan_count,
  output logic [1:0]  out_error_code
);

  localparam int FW = $clog2(PLAN_DEPTH + 1);
  localparam int IW = (PLAN_DEPTH > 1) ? $clog2(PLAN_DEPTH) : 1;

  // Sequencer and transport state.
  state_t            state_r, state_nxt;
  state_t            cm_ret_r, cm_ret_nxt;
  state_t            trg_ret_r, trg_ret_nxt;
  state_t            set_ret_r, set_ret_nxt;
  logic              set_ep_r, set_ep_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [31:0]       pos_r, pos_nxt;
  logic [31:0]       len_r, len_nxt;
  logic              epv_r, epv_nxt;
  logic [31:0]       epd_r, epd_nxt;
  logic              etav_r, etav_nxt;
  logic [31:0]       etac_r, etac_nxt;
  logic              trig_r, trig_nxt;
  logic              alrdy_r, alrdy_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [FW-1:0]     idx_r, idx_nxt;
  logic [2:0]        cm_m_r, cm_m_nxt;
  logic              cary_r, cary_nxt;
  logic [1:0]        err_r, err_nxt;
  logic              sync_en_r;

  // Item fields held for the length of the item.
  logic [2:0]        act_r;
  logic [15:0]       cnt_r;
  logic [2:0]        tmode_r;
  logic [15:0]       dly_r;
  logic              wait_r;
  logic [31:0]       val_r;
  logic              strig_r;
  logic              splay_r;
  logic              setav_r;
  logic [31:0]       seta_r;

  logic [31:0]       alu_a, alu_b;
  logic              alu_sub;
  logic [32:0]       alu_y;
  logic              own_v;
  logic              both_play;

  q_ctrl_t           q_ctrl;
  logic [CD_W-1:0]   q_rd_cd, q_head_cd;
  logic [2:0]        q_rd_mode, q_head_mode;

  ltsq_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  ltsq_plan_queue #(
    .PLAN_DEPTH (PLAN_DEPTH)
  ) u_queue (
    .clk       (clk),
    .ctrl      (q_ctrl),
    .idx       (idx_r[IW-1:0]),
    .rd_cd     (q_rd_cd),
    .rd_mode   (q_rd_mode),
    .head_cd   (q_head_cd),
    .head_mode (q_head_mode)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cm_ret_r  <= ST_DONE;
      trg_ret_r <= ST_DONE;
      set_ret_r <= ST_DONE;
      set_ep_r  <= 1'b0;
      mode_r    <= MODE_STOPPED;
      pos_r     <= '0;
      len_r     <= '0;
      epv_r     <= 1'b0;
      epd_r     <= '0;
      etav_r    <= 1'b0;
      etac_r    <= '0;
      trig_r    <= 1'b0;
      alrdy_r   <= 1'b0;
      fill_r    <= '0;
      idx_r     <= '0;
      cm_m_r    <= MODE_STOPPED;
      cary_r    <= 1'b0;
      err_r     <= ERR_NONE;
      sync_en_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cm_ret_r  <= cm_ret_nxt;
      trg_ret_r <= trg_ret_nxt;
      set_ret_r <= set_ret_nxt;
      set_ep_r  <= set_ep_nxt;
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      epv_r     <= epv_nxt;
      epd_r     <= epd_nxt;
      etav_r    <= etav_nxt;
      etac_r    <= etac_nxt;
      trig_r    <= trig_nxt;
      alrdy_r   <= alrdy_nxt;
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
      cm_m_r    <= cm_m_nxt;
      cary_r    <= cary_nxt;
      err_r     <= err_nxt;
      if (cfg_we) begin
        sync_en_r <= cfg_wdata;
      end
    end
  end

  // The item fields are captured when the item is taken.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r   <= in_action;
      cnt_r   <= in_sample_count;
      tmode_r <= in_target_mode;
      dly_r   <= in_delay_cycles;
      wait_r  <= in_wait_for_sync;
      val_r   <= in_new_value;
      strig_r <= in_sync_triggering;
      splay_r <= in_sync_playing;
      setav_r <= in_sync_eta_valid;
      seta_r  <= in_sync_eta;
    end
  end

  assign both_play = is_playing(mode_r) && is_playing(cm_m_r);
  // Own trigger prediction: playing and strictly before the loop end.
  assign own_v = is_playing(mode_r) && !alu_y[32] && (alu_y[31:0] != '0);

  always_comb begin
    state_nxt   = state_r;
    cm_ret_nxt  = cm_ret_r;
    trg_ret_nxt = trg_ret_r;
    set_ret_nxt = set_ret_r;
    set_ep_nxt  = set_ep_r;
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    epv_nxt     = epv_r;
    epd_nxt     = epd_r;
    etav_nxt    = etav_r;
    etac_nxt    = etac_r;
    trig_nxt    = trig_r;
    alrdy_nxt   = alrdy_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    cm_m_nxt    = cm_m_r;
    cary_nxt    = cary_r;
    err_nxt     = err_r;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b1;
    q_ctrl.op   = Q_NONE;
    q_ctrl.cd   = {1'b0, dly_r};
    q_ctrl.mode = tmode_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          err_nxt   = ERR_NONE;
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        state_nxt = ST_DONE;
        unique case (act_r)
          ACT_PROCESS: state_nxt = ST_P_CHK;
          ACT_PLAN: begin
            if (tmode_r > MODE_REC_DRY) begin
              err_nxt = ERR_INVALID;
            end else if ((!sync_en_r && mode_r != MODE_PLAY) || !wait_r) begin
              // Immediate change; the queue is dropped.
              fill_nxt   = '0;
              cm_m_nxt   = tmode_r;
              cm_ret_nxt = ST_PL_ETA;
              state_nxt  = ST_CM;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_PL_SRCH;
            end
          end
          ACT_SET_MODE: begin
            if (tmode_r > MODE_REC_DRY) begin
              err_nxt = ERR_INVALID;
            end else begin
              cm_m_nxt   = tmode_r;
              cm_ret_nxt = ST_DONE;
              state_nxt  = ST_CM;
            end
          end
          ACT_SET_POS: begin
            if (val_r != pos_r) begin
              pos_nxt     = val_r;
              set_ret_nxt = ST_DONE;
              set_ep_nxt  = 1'b1;
              state_nxt   = ST_S_ZERO;
            end
          end
          ACT_SET_LEN: begin
            if (val_r != len_r) begin
              len_nxt   = val_r;
              state_nxt = ST_L_CMP;
            end
          end
          ACT_CLEAR: fill_nxt = '0;
          ACT_SYNC: begin
            if (sync_en_r && strig_r) begin
              trg_ret_nxt = ST_DONE;
              state_nxt   = ST_T_START;
            end
          end
          default: ;
        endcase
      end

      ST_P_CHK: begin
        alu_a = epd_r;
        alu_b = 32'(cnt_r);
        if (epv_r && alu_y[32]) begin
          err_nxt   = ERR_BEYOND;
          state_nxt = ST_DONE;
        end else begin
          trig_nxt  = 1'b0;
          alrdy_nxt = 1'b0;
          if (epv_r) begin
            epd_nxt = alu_y[31:0];
          end
          state_nxt = ST_P_ADV;
        end
      end

      ST_P_ADV: begin
        alu_sub   = 1'b0;
        alu_b     = 32'(cnt_r);
        state_nxt = ST_P_ETA;
        if (mode_r == MODE_RECORD) begin
          alu_a   = len_r;
          len_nxt = alu_y[32] ? '1 : alu_y[31:0];
        end else if (mode_r == MODE_REPLACE) begin
          alu_a     = pos_r;
          pos_nxt   = alu_y[32] ? '1 : alu_y[31:0];
          state_nxt = ST_P_MAX;
        end else if (is_playing(mode_r)) begin
          // Tentative sum; clamped to the length in the next step.
          alu_a     = pos_r;
          pos_nxt   = alu_y[31:0];
          cary_nxt  = alu_y[32];
          state_nxt = ST_P_MIN;
        end
      end

      ST_P_MAX: begin
        alu_a = len_r;
        alu_b = pos_r;
        if (alu_y[32]) begin
          len_nxt = pos_r;
        end
        state_nxt = ST_P_ETA;
      end

      ST_P_MIN: begin
        alu_a = len_r;
        alu_b = pos_r;
        if (cary_r || alu_y[32]) begin
          pos_nxt = len_r;
        end
        state_nxt = ST_P_ETA;
      end

      ST_P_ETA: begin
        alu_a = etac_r;
        alu_b = 32'(cnt_r);
        if (etav_r) begin
          if (alu_y[32] || alu_y[31:0] == '0) begin
            etac_nxt = '0;
            etav_nxt = 1'b0;
          end else begin
            etac_nxt = alu_y[31:0];
          end
        end
        state_nxt = ST_P_END;
      end

      ST_P_END: begin
        if (epv_r && epd_r == '0) begin
          epv_nxt = 1'b0;
          if (!sync_en_r || !splay_r) begin
            trg_ret_nxt = ST_P_SETTLE;
            state_nxt   = ST_T_START;
          end else begin
            state_nxt = ST_P_SETTLE;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_P_SETTLE: begin
        set_ret_nxt = ST_DONE;
        set_ep_nxt  = 1'b1;
        state_nxt   = ST_S_ZERO;
      end

      ST_T_START: begin
        // Only the first trigger after a process item acts.
        if (alrdy_r) begin
          state_nxt = trg_ret_r;
        end else begin
          alrdy_nxt = 1'b1;
          trig_nxt  = 1'b1;
          alu_a     = pos_r;
          alu_b     = len_r;
          if (is_playing(mode_r) && !alu_y[32]) begin
            pos_nxt = '0;
          end
          idx_nxt   = '0;
          state_nxt = ST_T_DEC;
        end
      end

      ST_T_DEC: begin
        if (idx_r < fill_r) begin
          alu_a       = 32'(q_rd_cd);
          alu_b       = 32'd1;
          q_ctrl.op   = Q_WRITE;
          q_ctrl.cd   = alu_y[CD_W-1:0];
          q_ctrl.mode = q_rd_mode;
          idx_nxt     = idx_r + FW'(1);
        end else begin
          state_nxt = ST_T_POP;
        end
      end

      ST_T_POP: begin
        // Entries that counted below zero are applied in queue order.
        if (fill_r != '0 && q_head_cd[CD_W-1]) begin
          cm_m_nxt   = q_head_mode;
          q_ctrl.op  = Q_SHIFT;
          fill_nxt   = fill_r - FW'(1);
          cm_ret_nxt = ST_T_POP;
          state_nxt  = ST_CM;
        end else begin
          state_nxt = trg_ret_r;
        end
      end

      ST_CM: begin
        if (cm_m_r == mode_r) begin
          state_nxt = cm_ret_r;
        end else begin
          mode_nxt = cm_m_r;
          pos_nxt  = both_play ? pos_r : '0;
          len_nxt  = (cm_m_r == MODE_RECORD) ? '0 : len_r;
          if (is_playing(cm_m_r) && (!both_play || pos_r == '0)) begin
            trig_nxt = 1'b1;
          end
          set_ret_nxt = cm_ret_r;
          set_ep_nxt  = 1'b1;
          state_nxt   = ST_S_ZERO;
        end
      end

      ST_S_ZERO: begin
        // A playing loop of zero length stops.
        if (is_playing(mode_r) && len_r == '0) begin
          mode_nxt = MODE_STOPPED;
          pos_nxt  = '0;
        end
        state_nxt = ST_E_OWN;
      end

      ST_E_OWN: begin
        alu_a    = len_r;
        alu_b    = pos_r;
        etav_nxt = own_v;
        etac_nxt = own_v ? alu_y[31:0] : '0;
        if (set_ep_r) begin
          epv_nxt = own_v;
          epd_nxt = own_v ? alu_y[31:0] : '0;
        end
        state_nxt = ST_E_SRC;
      end

      ST_E_SRC: begin
        alu_a = seta_r;
        alu_b = etac_r;
        if (sync_en_r && setav_r) begin
          if (!etav_r || alu_y[32]) begin
            etac_nxt = seta_r;
          end
          etav_nxt = 1'b1;
        end
        state_nxt = set_ret_r;
      end

      ST_PL_SRCH: begin
        if (idx_r < fill_r) begin
          alu_a = 32'(q_rd_cd[15:0]);
          alu_b = 32'(dly_r);
          if (!alu_y[32]) begin
            state_nxt = ST_PL_INS;
          end else begin
            idx_nxt = idx_r + FW'(1);
          end
        end else if (fill_r == FW'(PLAN_DEPTH)) begin
          err_nxt   = ERR_FULL;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PL_INS;
        end
      end

      ST_PL_INS: begin
        // Later entries are dropped by the new fill.
        q_ctrl.op = Q_WRITE;
        fill_nxt  = idx_r + FW'(1);
        state_nxt = ST_PL_ETA;
      end

      ST_PL_ETA: begin
        set_ret_nxt = ST_DONE;
        set_ep_nxt  = 1'b0;
        state_nxt   = ST_E_OWN;
      end

      ST_L_CMP: begin
        alu_a = pos_r;
        alu_b = val_r;
        set_ret_nxt = ST_DONE;
        set_ep_nxt  = 1'b1;
        state_nxt   = alu_y[32] ? ST_S_ZERO : ST_L_POS;
      end

      ST_L_POS: begin
        alu_a     = val_r;
        alu_b     = 32'd1;
        pos_nxt   = (val_r == '0) ? '0 : alu_y[31:0];
        state_nxt = ST_S_ZERO;
      end

      ST_DONE: state_nxt = ST_IDLE;

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  assign out_mode_now        = mode_r;
  assign out_position_now    = pos_r;
  assign out_length_now      = len_r;
  assign out_triggering      = trig_r || (sync_en_r && strig_r);
  assign out_eta_valid       = etav_r;
  assign out_eta_samples     = etav_r ? etac_r : '0;
  assign out_next_plan_valid = (fill_r != '0);
  assign out_next_plan_mode  = (fill_r != '0) ? q_head_mode : MODE_STOPPED;
  assign out_next_plan_delay = (fill_r != '0) ? q_head_cd[15:0] : '0;
  assign out_plan_count      = 4'(fill_r);
  assign out_error_code      = err_r;

endmodule

/* dv/ltsq_checker.sv */
// ----------------------------------------------------------------------------
// Loop transport sequencer checker
// Watches the item and result channels, predicts every result and compares.
// ----------------------------------------------------------------------------
module ltsq_checker
  import ltsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_sample_count,
  input  logic [2:0]  in_target_mode,
  input  logic [15:0] in_delay_cycles,
  input  logic        in_wait_for_sync,
  input  logic [31:0] in_new_value,
  input  logic        in_sync_triggering,
  input  logic        in_sync_playing,
  input  logic        in_sync_eta_valid,
  input  logic [31:0] in_sync_eta,
  input  logic        out_valid,
  input  logic [2:0]  out_mode_now,
  input  logic [31:0] out_position_now,
  input  logic [31:0] out_length_now,
  input  logic        out_triggering,
  input  logic        out_eta_valid,
  input  logic [31:0] out_eta_samples,
  input  logic        out_next_plan_valid,
  input  logic [2:0]  out_next_plan_mode,
  input  logic [15:0] out_next_plan_delay,
  input  logic [3:0]  out_plan_count,
  input  logic [1:0]  out_error_code,
  output int          fail_count,
  output int          pending
);

  localparam int DEPTH      = PLAN_DEPTH_DEF;
  localparam int PEND_DEPTH = 4;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] position;
    logic [31:0] length;
    logic        trig;
    logic        eta_valid;
    logic [31:0] eta;
    logic        plan_valid;
    logic [2:0]  plan_mode;
    logic [15:0] plan_delay;
    logic [3:0]  plan_count;
    logic [1:0]  err;
  } transport_t;

  // Predicted results waiting for the block, as a small ring.
  transport_t pend_buf[PEND_DEPTH];
  int         rd_ptr, wr_ptr;

  logic [2:0]  mode_r;
  logic [31:0] pos_r, len_r, end_dist, eta_cnt, src_eta;
  bit          end_valid, eta_valid, trig_flag, trig_done;
  bit          sync_en, src_playing, src_eta_valid;
  logic [2:0]  plan_mode[DEPTH];
  int          plan_cd[DEPTH];
  int          fill;

  function automatic bit playing(logic [2:0] m);
    return m == MODE_PLAY || m == MODE_REPLACE || m == MODE_DRY_WET || m == MODE_REC_DRY;
  endfunction

  function automatic void refresh_eta();
    if (playing(mode_r) && pos_r < len_r) begin
      eta_valid = 1;
      eta_cnt = len_r - pos_r;
    end else begin
      eta_valid = 0;
      eta_cnt = 0;
    end
    if (sync_en && src_eta_valid) begin
      if (!eta_valid || src_eta < eta_cnt) eta_cnt = src_eta;
      eta_valid = 1;
    end
  endfunction

  // A playing loop whose length drops to zero stops itself; this is the full
  // net effect of that nested stop, so no recursion is needed.
  function automatic void stop_loop();
    mode_r = MODE_STOPPED;
    pos_r = 0;
    end_valid = 0;
    end_dist = 0;
    refresh_eta();
  endfunction

  function automatic void refresh_end();
    if (playing(mode_r) && len_r == 0) stop_loop();
    if (playing(mode_r) && pos_r < len_r) begin
      end_valid = 1;
      end_dist = len_r - pos_r;
    end else begin
      end_valid = 0;
      end_dist = 0;
    end
  endfunction

  function automatic void put_pos(logic [31:0] p);
    if (p != pos_r) begin
      pos_r = p;
      refresh_end();
      refresh_eta();
    end
  endfunction

  function automatic void put_len(logic [31:0] l);
    if (l != len_r) begin
      len_r = l;
      if (pos_r >= l) put_pos(l == 0 ? 32'd0 : l - 32'd1);
      refresh_end();
      refresh_eta();
    end
  endfunction

  function automatic void change_mode(logic [2:0] m);
    if (mode_r == m) return;
    if (!(playing(mode_r) && playing(m))) put_pos(0);
    if (m == MODE_RECORD) put_len(0);
    mode_r = m;
    if (m == MODE_STOPPED) pos_r = 0;
    if (playing(m) && pos_r == 0) trig_flag = 1;
    refresh_end();
    refresh_eta();
  endfunction

  function automatic void fire_trigger();
    if (trig_done) return;
    trig_done = 1;
    trig_flag = 1;
    if (playing(mode_r) && pos_r >= len_r) pos_r = 0;
    for (int i = 0; i < fill; i++) plan_cd[i] -= 1;
    while (fill > 0 && plan_cd[0] < 0) begin
      change_mode(plan_mode[0]);
      for (int k = 0; k < DEPTH - 1; k++) begin
        plan_mode[k] = plan_mode[k+1];
        plan_cd[k] = plan_cd[k+1];
      end
      fill--;
    end
  endfunction

  function automatic logic [1:0] advance(logic [15:0] n);
    logic [32:0] sum;
    logic [31:0] pos, len;
    if (end_valid && n > end_dist) return ERR_BEYOND;
    trig_flag = 0;
    trig_done = 0;
    pos = pos_r;
    len = len_r;
    if (mode_r == MODE_RECORD) begin
      sum = len + n;
      len = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end else if (mode_r == MODE_REPLACE) begin
      sum = pos + n;
      pos = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (pos > len) len = pos;
    end else if (playing(mode_r)) begin
      sum = pos + n;
      pos = (sum > {1'b0, len}) ? len : sum[31:0];
    end
    if (end_valid) end_dist -= n;
    pos_r = pos;
    len_r = len;
    if (eta_valid) begin
      eta_cnt = (eta_cnt > n) ? eta_cnt - n : 32'd0;
      if (eta_cnt == 0) eta_valid = 0;
    end
    // Reaching the loop end fires the loop's own trigger unless a playing
    // sync source is in charge.
    if (end_valid && end_dist == 0) begin
      end_valid = 0;
      if (!sync_en || !src_playing) fire_trigger();
      refresh_end();
      refresh_eta();
    end
    return ERR_NONE;
  endfunction

  function automatic logic [1:0] plan(logic [2:0] m, logic [15:0] delay, bit wait_sync);
    int i;
    if (m > MODE_REC_DRY) return ERR_INVALID;
    if ((!sync_en && mode_r != MODE_PLAY) || !wait_sync) begin
      change_mode(m);
      fill = 0;
    end else begin
      for (i = 0; i < fill; i++)
        if ($unsigned(plan_cd[i]) >= {16'd0, delay}) break;
      if (i >= fill && fill >= DEPTH) return ERR_FULL;
      // Inserting drops every later entry.
      plan_cd[i] = int'(delay);
      plan_mode[i] = m;
      fill = i + 1;
    end
    refresh_eta();
    return ERR_NONE;
  endfunction

  function automatic transport_t predict();
    transport_t t;
    logic [1:0] err;
    err = ERR_NONE;
    src_playing = in_sync_playing;
    src_eta_valid = in_sync_eta_valid;
    src_eta = in_sync_eta;
    case (in_action)
      ACT_PROCESS:  err = advance(in_sample_count);
      ACT_PLAN:     err = plan(in_target_mode, in_delay_cycles, in_wait_for_sync);
      ACT_SET_MODE: begin
        if (in_target_mode > MODE_REC_DRY) err = ERR_INVALID;
        else change_mode(in_target_mode);
      end
      ACT_SET_POS:  put_pos(in_new_value);
      ACT_SET_LEN:  put_len(in_new_value);
      ACT_CLEAR:    fill = 0;
      ACT_SYNC:     if (sync_en && in_sync_triggering) fire_trigger();
      default:      ;
    endcase
    t.mode = mode_r;
    t.position = pos_r;
    t.length = len_r;
    t.trig = trig_flag || (sync_en && in_sync_triggering);
    t.eta_valid = eta_valid;
    t.eta = eta_valid ? eta_cnt : 32'd0;
    t.plan_valid = fill > 0;
    t.plan_mode = fill > 0 ? plan_mode[0] : 3'd0;
    t.plan_delay = fill > 0 ? plan_cd[0][15:0] : 16'd0;
    t.plan_count = fill[3:0];
    t.err = err;
    return t;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    transport_t t;
    if (!rst_n) begin
      mode_r = MODE_STOPPED;
      pos_r = 0; len_r = 0; end_dist = 0; eta_cnt = 0; src_eta = 0;
      end_valid = 0; eta_valid = 0; trig_flag = 0; trig_done = 0;
      sync_en = 0; src_playing = 0; src_eta_valid = 0;
      fill = 0;
      for (int i = 0; i < DEPTH; i++) begin
        plan_mode[i] = 0;
        plan_cd[i] = 0;
      end
      rd_ptr = 0;
      wr_ptr = 0;
      fail_count = 0;
    end else begin
      if (cfg_we) sync_en = cfg_wdata;
      if (out_valid) begin
        if (wr_ptr == rd_ptr) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          t = pend_buf[rd_ptr % PEND_DEPTH];
          rd_ptr++;
          check_field("mode_now", t.mode, out_mode_now);
          check_field("position_now", t.position, out_position_now);
          check_field("length_now", t.length, out_length_now);
          check_field("triggering", t.trig, out_triggering);
          check_field("eta_valid", t.eta_valid, out_eta_valid);
          check_field("eta_samples", t.eta, out_eta_samples);
          check_field("next_plan_valid", t.plan_valid, out_next_plan_valid);
          check_field("next_plan_mode", t.plan_mode, out_next_plan_mode);
          check_field("next_plan_delay", t.plan_delay, out_next_plan_delay);
          check_field("plan_count", t.plan_count, out_plan_count);
          check_field("error_code", t.err, out_error_code);
        end
      end
      if (start && !busy) begin
        if (wr_ptr - rd_ptr >= PEND_DEPTH) begin
          $error("more items outstanding than the checker holds");
          fail_count++;
        end
        pend_buf[wr_ptr % PEND_DEPTH] = predict();
        wr_ptr++;
      end
    end
    pending = wr_ptr - rd_ptr;
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Loop transport sequencer testbench
// Directed and random items in three idle patterns with both sync settings.
// ----------------------------------------------------------------------------
module tb;
  import ltsq_pkg::*;

  // A generous limit on the length of the whole run.
  localparam int CYCLE_LIMIT = 300000;

  // Codes outside the defined sets.
  localparam logic [2:0] ACT_RESERVED = 3'd7;
  localparam logic [2:0] MODE_BAD_LO  = 3'd6;
  localparam logic [2:0] MODE_BAD_HI  = 3'd7;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic        cfg_wdata = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_action = ACT_PROCESS;
  logic [15:0] in_sample_count = 0;
  logic [2:0]  in_target_mode = MODE_STOPPED;
  logic [15:0] in_delay_cycles = 0;
  logic        in_wait_for_sync = 0;
  logic [31:0] in_new_value = 0;
  logic        in_sync_triggering = 0;
  logic        in_sync_playing = 0;
  logic        in_sync_eta_valid = 0;
  logic [31:0] in_sync_eta = 0;
  logic        out_valid;
  logic [2:0]  out_mode_now;
  logic [31:0] out_position_now, out_length_now, out_eta_samples;
  logic        out_triggering, out_eta_valid, out_next_plan_valid;
  logic [2:0]  out_next_plan_mode;
  logic [15:0] out_next_plan_delay;
  logic [3:0]  out_plan_count;
  logic [1:0]  out_error_code;
  int          fail_count, pending;
  int          cycles = 0;
  int          idle_pct = 0;

  // The last reported position and length steer process sizes so that the
  // loop end is hit exactly often enough to fire triggers.
  logic [31:0] seen_pos = 0, seen_len = 0;

  loop_transport_sequencer_core DUT (.*);
  ltsq_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid) begin
      seen_pos <= out_position_now;
      seen_len <= out_length_now;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("loop_transport_sequencer_core: mismatch");
      $finish;
    end
  end

  // Sends one item. It is called at a falling edge and returns at the falling
  // edge after the item was taken, with start still high.
  task automatic send(logic [2:0] act, logic [15:0] cnt, logic [2:0] mode,
                      logic [15:0] dly, logic wt, logic [31:0] val,
                      logic s_trig, logic s_play, logic s_ev, logic [31:0] s_eta);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1;
    in_action <= act;
    in_sample_count <= cnt;
    in_target_mode <= mode;
    in_delay_cycles <= dly;
    in_wait_for_sync <= wt;
    in_new_value <= val;
    in_sync_triggering <= s_trig;
    in_sync_playing <= s_play;
    in_sync_eta_valid <= s_ev;
    in_sync_eta <= s_eta;
    // busy only moves at rising edges, so its value here decides the next edge.
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Lowers start and waits until the block has delivered its last result.
  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (busy || pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_sync(logic v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_item();
    logic [2:0]  act, mode;
    logic [15:0] cnt, dly;
    logic [31:0] val, rem, s_eta;
    int          r;
    r = $urandom_range(99);
    if (r < 35) act = ACT_PROCESS;
    else if (r < 55) act = ACT_PLAN;
    else if (r < 67) act = ACT_SET_MODE;
    else if (r < 73) act = ACT_SET_POS;
    else if (r < 81) act = ACT_SET_LEN;
    else if (r < 85) act = ACT_CLEAR;
    else if (r < 98) act = ACT_SYNC;
    else act = ACT_RESERVED;

    rem = (seen_len > seen_pos) ? seen_len - seen_pos : 32'd0;
    r = $urandom_range(99);
    if (r < 40) cnt = (rem > 65535) ? 16'($urandom) : rem[15:0];
    else if (r < 70) cnt = 16'($urandom_range(0, (rem > 65535) ? 65535 : rem));
    else if (r < 85) cnt = 16'($urandom);
    else cnt = 16'($urandom_range(0, 16));

    mode = ($urandom_range(99) < 90) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));

    r = $urandom_range(99);
    if (r < 80) dly = 16'($urandom_range(0, 4));
    else if (r < 90) dly = 16'($urandom);
    else dly = 16'hFFFF;

    r = $urandom_range(99);
    if (act == ACT_SET_POS && r < 70 && seen_len != 0) val = $urandom_range(0, seen_len - 1);
    else if (r < 10) val = 0;
    else if (r < 75) val = $urandom_range(1, 300);
    else if (r < 90) val = $urandom;
    else val = 32'hFFFF_FFFF;

    s_eta = ($urandom_range(1)) ? 32'($urandom_range(0, 64)) : 32'($urandom);
    send(act, cnt, mode, dly, $urandom_range(99) < 70, val,
         1'($urandom_range(1)), $urandom_range(99) < 40, 1'($urandom_range(1)), s_eta);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    write_sync(0);

    // Play a short loop, hit its end and plan changes on the trigger.
    send(ACT_SET_LEN,  0, 0, 0, 0, 100, 0, 0, 0, 0);
    send(ACT_SET_MODE, 0, MODE_PLAY, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_PROCESS, 40, 0, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_PROCESS, 61, 0, 0, 0, 0, 0, 0, 0, 0);   // beyond the loop end
    send(ACT_PROCESS, 60, 0, 0, 0, 0, 0, 0, 0, 0);   // exactly at the loop end
    for (int i = 0; i < 8; i++)
      send(ACT_PLAN, 0, MODE_DRY_WET, 16'(i + 1), 1, 0, 0, 0, 0, 0);
    send(ACT_PLAN, 0, MODE_REPLACE, 16'hFFFF, 1, 0, 0, 0, 0, 0);  // queue full
    send(ACT_PLAN, 0, MODE_BAD_LO, 0, 1, 0, 0, 0, 0, 0);          // invalid mode
    send(ACT_SET_MODE, 0, MODE_BAD_HI, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_PROCESS, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_PROCESS, 100, 0, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_SYNC, 0, 0, 0, 0, 0, 1, 1, 1, 32'hFFFF_FFFF);       // sync disabled
    send(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_RESERVED, 16'hFFFF, MODE_BAD_HI, 16'hFFFF, 1, 32'hFFFF_FFFF, 1, 1, 1,
         32'hFFFF_FFFF);
    // Saturation of the position in replace and of the length in record.
    send(ACT_SET_MODE, 0, MODE_REPLACE, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_SET_LEN,  0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send(ACT_SET_POS,  0, 0, 0, 0, 32'hFFFF_FFF0, 0, 0, 0, 0);
    send(ACT_PROCESS, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_SET_MODE, 0, MODE_RECORD, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_SET_LEN,  0, 0, 0, 0, 32'hFFFF_FFFE, 0, 0, 0, 0);
    send(ACT_PROCESS, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_SET_LEN,  0, 0, 0, 0, 0, 0, 0, 0, 0);

    write_sync(1);
    idle_pct = 14;
    repeat (130) random_item();
    write_sync(0);
    idle_pct = 69;
    repeat (130) random_item();
    write_sync(1);
    idle_pct = 0;
    repeat (140) random_item();

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("loop_transport_sequencer_core: match");
    end else begin
      $display("loop_transport_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule
